// ===== sv/emrx_pkg.sv =====
// emrx_pkg: widths, constants, codes, shared types and helper functions
// for the Ethernet receive filter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package emrx_pkg;

  localparam int MAC_W     = 48;
  localparam int LEN_W     = 14;
  localparam int CFG_IDX_W = 8;
  localparam int CRC_W     = 32;

  // frame layout, counted in bytes from the start of the frame
  localparam logic [LEN_W-1:0] DEST_END     = 14'd6;
  localparam logic [LEN_W-1:0] SRC_END      = 14'd12;
  localparam logic [LEN_W-1:0] HEADER_BYTES = 14'd14;
  localparam logic [LEN_W-1:0] MIN_FRAME    = 14'd18;
  localparam logic [LEN_W-1:0] POS_MAX      = 14'h3FFF;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [MAC_W-1:0] DEST_A_RST = 48'h1111_1111_1111;
  localparam logic [MAC_W-1:0] DEST_B_RST = 48'h0009_7307_7473;
  localparam logic [MAC_W-1:0] SRC_A_RST  = 48'h1111_1111_1111;
  localparam logic [MAC_W-1:0] SRC_B_RST  = 48'h0009_7307_7473;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_B = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_A  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_B  = 8'd3;

  // verdict codes
  localparam logic [2:0] VERD_OK      = 3'd0;
  localparam logic [2:0] VERD_DEST    = 3'd1;
  localparam logic [2:0] VERD_SRC     = 3'd2;
  localparam logic [2:0] VERD_CRC     = 3'd3;
  localparam logic [2:0] VERD_SHORT   = 3'd4;

  // one byte on its way through the processing stage
  typedef struct packed {
    logic             step;   // byte is consumed this cycle
    logic             clear;  // byte ends the frame
    logic [LEN_W-1:0] pos;    // bytes of the frame seen before this one
    logic [7:0]       data;
  } beat_t;

  // header match status after the current byte
  typedef struct packed {
    logic [1:0]  dest_bits;   // bit0 still equals a, bit1 still equals b
    logic [1:0]  src_bits;
    logic [15:0] frame_type;
  } hdr_stat_t;

  // byte idx of a MAC, first byte most significant
  function automatic logic [7:0] mac_byte_f(input logic [MAC_W-1:0] mac,
                                            input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // one byte step of the reflected CRC: (crc >> 8) ^ T[(crc ^ b) & 0xFF]
  function automatic logic [CRC_W-1:0] crc_byte_f(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = {24'h0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return (crc >> 8) ^ c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/emrx_ifs.sv =====
// emrx_ifs: valid/ready channel interfaces for the byte input, the
// verdict output and the configuration write port. Depends on emrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface emrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface emrx_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  verdict;
  logic                        dest_slot;
  logic [emrx_pkg::LEN_W-1:0]  frame_length;
  logic [15:0]                 frame_type;
  modport source (output valid, verdict, dest_slot, frame_length, frame_type,
                  input ready);
  modport sink   (input valid, verdict, dest_slot, frame_length, frame_type,
                  output ready);
endinterface

interface emrx_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [emrx_pkg::CFG_IDX_W-1:0]  index;
  logic [emrx_pkg::MAC_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/emrx_hdr_match.sv =====
// emrx_hdr_match: destination/source MAC compare and frame type capture,
// one header byte per step. Depends on emrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emrx_hdr_match (
  input  logic                              clk,
  input  logic                              rst_n,
  input  emrx_pkg::beat_t                   beat,
  input  logic [emrx_pkg::MAC_W-1:0]        dest_a,
  input  logic [emrx_pkg::MAC_W-1:0]        dest_b,
  input  logic [emrx_pkg::MAC_W-1:0]        src_a,
  input  logic [emrx_pkg::MAC_W-1:0]        src_b,
  output emrx_pkg::hdr_stat_t               stat
);
  import emrx_pkg::*;

  logic [1:0]       dest_r, dest_nxt;
  logic [1:0]       src_r, src_nxt;
  logic [15:0]      type_r, type_nxt;
  logic [LEN_W-1:0] src_off;
  logic             in_dest, in_src, in_type;

  assign in_dest = beat.pos < DEST_END;
  assign in_src  = !in_dest && (beat.pos < SRC_END);
  assign in_type = (beat.pos >= SRC_END) && (beat.pos < HEADER_BYTES);
  assign src_off = beat.pos - DEST_END;

  always_comb begin
    dest_nxt = dest_r;
    src_nxt  = src_r;
    type_nxt = type_r;
    if (in_dest) begin
      dest_nxt = dest_r & ~{beat.data != mac_byte_f(dest_b, beat.pos[2:0]),
                            beat.data != mac_byte_f(dest_a, beat.pos[2:0])};
    end else if (in_src) begin
      src_nxt = src_r & ~{beat.data != mac_byte_f(src_b, src_off[2:0]),
                          beat.data != mac_byte_f(src_a, src_off[2:0])};
    end else if (in_type) begin
      type_nxt = {type_r[7:0], beat.data};
    end
  end

  assign stat.dest_bits  = dest_nxt;
  assign stat.src_bits   = src_nxt;
  assign stat.frame_type = type_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= 2'b11;
      src_r  <= 2'b11;
      type_r <= 16'h0;
    end else if (beat.step) begin
      if (beat.clear) begin
        dest_r <= 2'b11;
        src_r  <= 2'b11;
        type_r <= 16'h0;
      end else begin
        dest_r <= dest_nxt;
        src_r  <= src_nxt;
        type_r <= type_nxt;
      end
    end
  end

  // match bits only ever drop within a frame
  a_dest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && !beat.clear |=> (dest_r & ~$past(dest_r)) == 2'b00)
    else $error("destination match bit set mid-frame");
  a_src_hold: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && !beat.clear && in_dest |=> src_r == $past(src_r))
    else $error("source match changed during destination bytes");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && beat.clear |=> dest_r == 2'b11 && src_r == 2'b11 && type_r == 16'h0)
    else $error("header state not cleared at frame end");

endmodule

`default_nettype wire

// ===== sv/emrx_crc_check.sv =====
// emrx_crc_check: four-byte trailer delay line and CRC-32 over the payload,
// one byte per step. Depends on emrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module emrx_crc_check (
  input  logic            clk,
  input  logic            rst_n,
  input  emrx_pkg::beat_t beat,
  output logic            crc_ok
);
  import emrx_pkg::*;

  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] trail_r, trail_nxt;

  // the byte leaving the delay line goes into the CRC once it is known
  // not to be part of the trailer
  always_comb begin
    crc_nxt   = crc_r;
    trail_nxt = trail_r;
    if (beat.pos >= HEADER_BYTES) begin
      if (beat.pos >= MIN_FRAME) begin
        crc_nxt = crc_byte_f(crc_r, trail_r[7:0]);
      end
      trail_nxt = {beat.data, trail_r[31:8]};
    end
  end

  assign crc_ok = (crc_nxt ^ CRC_INIT) == trail_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      trail_r <= '0;
    end else if (beat.step) begin
      if (beat.clear) begin
        crc_r   <= CRC_INIT;
        trail_r <= '0;
      end else begin
        crc_r   <= crc_nxt;
        trail_r <= trail_nxt;
      end
    end
  end

  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && !beat.clear && beat.pos < MIN_FRAME |=> crc_r == CRC_INIT)
    else $error("CRC moved before payload reached it");
  a_trail_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && !beat.clear && beat.pos < HEADER_BYTES |=> trail_r == '0)
    else $error("trailer window loaded during header");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !beat.step |=> $stable(crc_r) && $stable(trail_r))
    else $error("CRC state moved without a byte");

endmodule

`default_nettype wire

// ===== sv/ethernet_rx_mac_filter_crc_check_top.sv =====
// Ethernet receive filter, top level.
// Channels: in_stream (sink) takes one frame byte per word with a last-byte
// mark; out_stream (source) gives one verdict word per frame; cfg_wr (sink)
// writes the four 48-bit MAC registers, index 0..3, other indexes ignored.
// cfg_wr.ready is always high; each write goes straight into its register.
// Each accepted byte is held in the input register, then the header
// compare and the CRC step run in one combinational pass into the result
// register, which holds the verdict word of the frame's last byte.
// Throughput is one byte per clock, unless a last byte waits as below.
// When out_stream stalls, further bytes of the next frame still flow until
// its last byte reaches the input register; that byte then waits for the
// result register to drain, and in_stream.ready drops until it does.
// Reset (rst_n low, synchronous) empties both registers, clears the frame
// state and restores the MAC registers to their defaults.
// Depends on emrx_pkg, emrx_ifs, emrx_hdr_match and emrx_crc_check.
`timescale 1ns / 1ps
`default_nettype none

module ethernet_rx_mac_filter_crc_check_top (
  input  logic        clk,
  input  logic        rst_n,
  emrx_in_if.sink     in_stream,
  emrx_out_if.source  out_stream,
  emrx_cfg_if.sink    cfg_wr
);
  import emrx_pkg::*;

  // configuration registers
  logic [MAC_W-1:0] dest_a_r, dest_b_r, src_a_r, src_b_r;

  // input register
  logic             in_v_r;
  logic [7:0]       byte_r;
  logic             last_r;

  // frame position, saturating
  logic [LEN_W-1:0] pos_r, pos_nxt;

  // result register
  logic             out_v_r;
  logic [2:0]       verdict_r;
  logic             slot_r;
  logic [LEN_W-1:0] len_r;
  logic [15:0]      type_r;

  beat_t            beat;
  hdr_stat_t        hdr;
  logic             crc_ok;
  logic             out_free;
  logic [2:0]       verdict;
  logic             slot;

  assign out_free   = !out_v_r || out_stream.ready;
  assign beat.step  = in_v_r && (!last_r || out_free);
  assign beat.clear = last_r;
  assign beat.pos   = pos_r;
  assign beat.data  = byte_r;

  assign in_stream.ready = !in_v_r || beat.step;
  assign cfg_wr.ready    = 1'b1;

  assign pos_nxt = (pos_r == POS_MAX) ? POS_MAX : pos_r + 14'd1;

  emrx_hdr_match u_hdr (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .dest_a (dest_a_r),
    .dest_b (dest_b_r),
    .src_a  (src_a_r),
    .src_b  (src_b_r),
    .stat   (hdr)
  );

  emrx_crc_check u_crc (
    .clk    (clk),
    .rst_n  (rst_n),
    .beat   (beat),
    .crc_ok (crc_ok)
  );

  always_comb begin
    if (pos_nxt < MIN_FRAME) begin
      verdict = VERD_SHORT;
    end else if (hdr.dest_bits == 2'b00) begin
      verdict = VERD_DEST;
    end else if (hdr.src_bits == 2'b00) begin
      verdict = VERD_SRC;
    end else if (!crc_ok) begin
      verdict = VERD_CRC;
    end else begin
      verdict = VERD_OK;
    end
    slot = !hdr.dest_bits[0] && hdr.dest_bits[1] && (verdict != VERD_DEST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_a_r <= DEST_A_RST;
      dest_b_r <= DEST_B_RST;
      src_a_r  <= SRC_A_RST;
      src_b_r  <= SRC_B_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_DEST_A: dest_a_r <= cfg_wr.data;
        CFG_DEST_B: dest_b_r <= cfg_wr.data;
        CFG_SRC_A:  src_a_r  <= cfg_wr.data;
        CFG_SRC_B:  src_b_r  <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_stream.ready) begin
      in_v_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      byte_r <= in_stream.data_byte;
      last_r <= in_stream.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (beat.step) begin
      pos_r <= last_r ? '0 : pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (beat.step && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.step && last_r) begin
      verdict_r <= verdict;
      slot_r    <= slot;
      len_r     <= pos_nxt;
      type_r    <= hdr.frame_type;
    end
  end

  assign out_stream.valid        = out_v_r;
  assign out_stream.verdict      = verdict_r;
  assign out_stream.dest_slot    = slot_r;
  assign out_stream.frame_length = len_r;
  assign out_stream.frame_type   = type_r;

  a_len_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((len_r < MIN_FRAME) == (verdict_r == VERD_SHORT)))
    else $error("short-frame verdict disagrees with length");
  a_slot_dest: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && verdict_r == VERD_DEST |-> !slot_r)
    else $error("slot set on destination mismatch");
  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && last_r |=> pos_r == '0)
    else $error("position not cleared after frame end");
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    beat.step && !last_r && pos_r == POS_MAX |=> pos_r == POS_MAX)
    else $error("position wrapped past saturation");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !beat.step |=> in_v_r && $stable(byte_r) && $stable(last_r))
    else $error("stalled input byte lost");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench: self-checking bench for the Ethernet receive filter top level.
// Drives frames byte by byte, predicts each verdict word and checks it.
// Depends on emrx_pkg, emrx_ifs and ethernet_rx_mac_filter_crc_check_top.
`timescale 1ns / 1ps

module testbench;
  import emrx_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_END = CFG_SRC_B + 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP  = '1;
  localparam logic [MAC_W-1:0] MAC_ONES = '1;
  localparam logic [MAC_W-1:0] MAC_ZERO = '0;

  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int unsigned gap;
  } wire_byte_t;

  typedef struct packed {
    logic [2:0]       verdict;
    logic             slot;
    logic [LEN_W-1:0] length;
    logic [15:0]      ftype;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  emrx_in_if  in_ch ();
  emrx_out_if out_ch ();
  emrx_cfg_if cfg_ch ();

  ethernet_rx_mac_filter_crc_check_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_wr     (cfg_ch)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_DEST_A;
    cfg_ch.data = MAC_ZERO;
  end

  wire_byte_t     byte_q[$];
  verdict_t       verdicts_due[$];
  logic [7:0]     frame_buf[$];
  logic [MAC_W-1:0] reg_file [0:3];

  // predicted frame state
  logic [LEN_W-1:0] run_pos;
  logic [CRC_W-1:0] run_crc;
  logic [31:0]      tail_win;
  logic [1:0]       dest_hits;
  logic [1:0]       src_hits;
  logic [15:0]      type_acc;

  bit          calm = 1'b0;
  int unsigned fails = 0;
  int unsigned sent_bytes = 0;
  int unsigned sent_frames = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] octet_of(input logic [MAC_W-1:0] mac, input logic [2:0] i);
    return mac[8*(5-i) +: 8];
  endfunction

  // reflected CRC-32, one bit at a time, LSB first
  function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] c,
                                                  input logic [7:0] d);
    logic [CRC_W-1:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ d[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    m[47:32] = 16'($urandom_range(0, 16'hFFFF));
    m[31:0] = $urandom;
    return m;
  endfunction

  // same address with one whole byte changed
  function automatic logic [MAC_W-1:0] near_mac(input logic [MAC_W-1:0] m);
    return m ^ ({40'h0, 8'($urandom_range(1, 255))} << (8 * $urandom_range(0, 5)));
  endfunction

  function automatic logic [MAC_W-1:0] pick_addr(input logic [MAC_W-1:0] a,
                                                 input logic [MAC_W-1:0] b);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return a;
    if (r < 8) return b;
    if (r == 8) return near_mac(r[0] ? a : b);
    return rand_mac();
  endfunction

  task automatic clear_frame();
    run_pos = '0;
    run_crc = CRC_INIT;
    tail_win = '0;
    dest_hits = 2'b11;
    src_hits = 2'b11;
    type_acc = '0;
  endtask

  task automatic track_byte(input logic [7:0] d, input logic fin);
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] len;
    verdict_t v;
    p = run_pos;
    if (p < DEST_END) begin
      if (d != octet_of(reg_file[CFG_DEST_A], p[2:0])) dest_hits[0] = 1'b0;
      if (d != octet_of(reg_file[CFG_DEST_B], p[2:0])) dest_hits[1] = 1'b0;
    end else if (p < SRC_END) begin
      off = p - DEST_END;
      if (d != octet_of(reg_file[CFG_SRC_A], off[2:0])) src_hits[0] = 1'b0;
      if (d != octet_of(reg_file[CFG_SRC_B], off[2:0])) src_hits[1] = 1'b0;
    end else if (p < HEADER_BYTES) begin
      type_acc = {type_acc[7:0], d};
    end else begin
      // the oldest byte of the window leaves the trailer and enters the CRC
      if (p >= MIN_FRAME) run_crc = crc_update(run_crc, tail_win[7:0]);
      tail_win = {d, tail_win[31:8]};
    end
    len = (p == POS_MAX) ? POS_MAX : p + 1'b1;
    run_pos = len;
    if (fin) begin
      v.slot = ~dest_hits[0] & dest_hits[1];
      if (len < MIN_FRAME) v.verdict = VERD_SHORT;
      else if (dest_hits == 2'b00) v.verdict = VERD_DEST;
      else if (src_hits == 2'b00) v.verdict = VERD_SRC;
      else if ((run_crc ^ CRC_INIT) != tail_win) v.verdict = VERD_CRC;
      else v.verdict = VERD_OK;
      if (v.verdict == VERD_DEST) v.slot = 1'b0;
      v.length = len;
      v.ftype = type_acc;
      verdicts_due.push_back(v);
      clear_frame();
    end
  endtask

  // ---- frame building ----
  task automatic add_mac(input logic [MAC_W-1:0] m);
    for (int i = 0; i < 6; i++) frame_buf.push_back(octet_of(m, i[2:0]));
  endtask

  task automatic add_payload(input int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // FCS over everything after the header, little-endian, optionally damaged
  task automatic add_fcs(input bit bad);
    logic [CRC_W-1:0] c;
    int unsigned at;
    c = CRC_INIT;
    for (int i = HEADER_BYTES; i < frame_buf.size(); i++) c = crc_update(c, frame_buf[i]);
    c = ~c;
    if (bad) c = c ^ ({24'h0, 8'($urandom_range(1, 255))} << (8 * $urandom_range(0, 3)));
    for (int i = 0; i < 4; i++) frame_buf.push_back(c[8*i +: 8]);
  endtask

  task automatic build_frame(input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
                             input logic [15:0] ftype, input int unsigned n, input bit bad);
    add_mac(dst);
    add_mac(src);
    frame_buf.push_back(ftype[15:8]);
    frame_buf.push_back(ftype[7:0]);
    add_payload(n);
    add_fcs(bad);
  endtask

  task automatic cut_frame(input int unsigned keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  task automatic send_frame();
    wire_byte_t w;
    for (int i = 0; i < frame_buf.size(); i++) begin
      w.data = frame_buf[i];
      w.fin = (i == frame_buf.size() - 1);
      w.gap = draw_gap();
      byte_q.push_back(w);
    end
    sent_bytes += frame_buf.size();
    sent_frames++;
    frame_buf.delete();
  endtask

  task automatic random_frame();
    logic [MAC_W-1:0] dst;
    logic [MAC_W-1:0] src;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 9);
    dst = pick_addr(reg_file[CFG_DEST_A], reg_file[CFG_DEST_B]);
    src = pick_addr(reg_file[CFG_SRC_A], reg_file[CFG_SRC_B]);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120) : $urandom_range(0, 12);
    if (kind < 8) begin
      build_frame(dst, src, 16'($urandom_range(0, 16'hFFFF)), n, $urandom_range(0, 4) == 0);
    end else if (kind == 8) begin
      build_frame(dst, src, 16'($urandom_range(0, 16'hFFFF)), n, 1'b0);
      cut_frame($urandom_range(1, MIN_FRAME - 1));
    end else begin
      add_payload($urandom_range(1, 40));
    end
    send_frame();
  endtask

  // wait for the block to run dry, then let the pipeline empty
  task automatic settle();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_ch.valid || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_traffic(input int unsigned min_bytes, input int unsigned min_frames);
    int unsigned b0;
    int unsigned f0;
    b0 = sent_bytes;
    f0 = sent_frames;
    while (sent_bytes - b0 < min_bytes || sent_frames - f0 < min_frames) random_frame();
    settle();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx <= CFG_SRC_B) reg_file[idx[1:0]] = val;
    @(negedge clk);
  endtask

  // ---- byte driver ----
  always @(posedge clk) begin : feed
    wire_byte_t nxt;
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      nv = 1'b0;
      if (byte_q.size() > 0) begin
        if (byte_q[0].gap > 0) begin
          byte_q[0].gap = byte_q[0].gap - 1;
        end else begin
          nxt = byte_q.pop_front();
          in_ch.data_byte <= nxt.data;
          in_ch.last_byte <= nxt.fin;
          nv = 1'b1;
        end
      end
      in_ch.valid <= nv;
    end
  end

  // ---- verdict receiver ----
  always @(posedge clk) begin : drain_side
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (out_ch.valid && out_ch.ready) stall_left = draw_gap();
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---- input watch: feeds the predictor ----
  always @(posedge clk) begin : byte_watch
    if (!rst_n) begin
      reg_file[CFG_DEST_A] = DEST_A_RST;
      reg_file[CFG_DEST_B] = DEST_B_RST;
      reg_file[CFG_SRC_A] = SRC_A_RST;
      reg_file[CFG_SRC_B] = SRC_B_RST;
      clear_frame();
    end else if (in_ch.valid && in_ch.ready) begin
      track_byte(in_ch.data_byte, in_ch.last_byte);
    end
  end

  // ---- verdict check ----
  always @(posedge clk) begin : verdict_watch
    verdict_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("verdict word with none expected: verdict %0d length %0d",
               out_ch.verdict, out_ch.frame_length);
        fails++;
      end else begin
        want = verdicts_due.pop_front();
        if (out_ch.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_ch.verdict);
          fails++;
        end
        if (out_ch.dest_slot !== want.slot) begin
          $error("dest_slot: expected %0d, got %0d", want.slot, out_ch.dest_slot);
          fails++;
        end
        if (out_ch.frame_length !== want.length) begin
          $error("frame_length: expected %0d, got %0d", want.length, out_ch.frame_length);
          fails++;
        end
        if (out_ch.frame_type !== want.ftype) begin
          $error("frame_type: expected %h, got %h", want.ftype, out_ch.frame_type);
          fails++;
        end
      end
    end
  end

  // ---- watchdog: too long with no word moving anywhere ----
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames against the reset addresses
    build_frame(DEST_A_RST, SRC_A_RST, 16'h0800, 0, 1'b0);      // destination slot A, no payload
    send_frame();
    add_mac(DEST_B_RST);
    add_mac(SRC_B_RST);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h55);
    frame_buf.push_back(8'hAA);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(8'h80);
    add_fcs(1'b0);
    send_frame();
    // dest wins over source and crc faults
    build_frame(near_mac(DEST_B_RST), near_mac(SRC_A_RST), 16'h0000, 5, 1'b1);
    send_frame();
    // source wins over crc fault
    build_frame(DEST_A_RST, near_mac(SRC_A_RST), 16'h86DD, 2, 1'b1);
    send_frame();
    build_frame(DEST_B_RST, SRC_A_RST, 16'h0806, 3, 1'b1);
    send_frame();
    frame_buf.push_back(8'hFF);                                   // one-byte frame
    send_frame();
    build_frame(DEST_B_RST, SRC_B_RST, 16'hA55A, 0, 1'b0);        // ends inside the type
    cut_frame(HEADER_BYTES - 1);
    send_frame();
    build_frame(DEST_A_RST, SRC_B_RST, 16'h1234, 0, 1'b0);        // one byte short
    cut_frame(MIN_FRAME - 1);
    send_frame();
    settle();

    write_reg(CFG_DEST_A, MAC_ONES);
    write_reg(CFG_DEST_B, rand_mac());
    write_reg(CFG_SRC_A, MAC_ZERO);
    write_reg(CFG_SRC_B, rand_mac());
    write_reg(CFG_PAST_END, rand_mac());                          // ignored
    write_reg(CFG_IDX_TOP, rand_mac());                           // ignored
    random_traffic(90, 3);

    // both destination slots equal; back-to-back sender against a long receiver hold
    write_reg(CFG_DEST_A, DEST_B_RST);
    write_reg(CFG_DEST_B, DEST_B_RST);
    write_reg(CFG_SRC_A, MAC_ONES);
    write_reg(CFG_SRC_B, MAC_ZERO);
    calm = 1'b1;
    hold_asks++;
    random_traffic(90, 3);
    calm = 1'b0;

    write_reg(CFG_DEST_A, rand_mac());
    write_reg(CFG_DEST_B, rand_mac());
    write_reg(CFG_SRC_A, rand_mac());
    write_reg(CFG_SRC_B, rand_mac());
    random_traffic(90, 3);

    write_reg(CFG_DEST_A, MAC_ZERO);
    write_reg(CFG_DEST_B, MAC_ONES);
    write_reg(CFG_SRC_A, rand_mac());
    write_reg(CFG_SRC_B, MAC_ONES);
    random_traffic(90, 3);

    // back-to-back frames against the final addresses
    calm = 1'b1;
    build_frame(reg_file[CFG_DEST_B], reg_file[CFG_SRC_A], 16'hFFFF, 6, 1'b0);
    send_frame();
    build_frame(reg_file[CFG_DEST_A], reg_file[CFG_SRC_B], 16'h0001, 0, 1'b0);
    send_frame();
    settle();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
